>>> sv/irrs_pkg.sv
// Shared types, constants and helpers for the ICMP reply RTT statistics block.
// No dependencies; every other file depends on this package.
package irrs_pkg;

	localparam int SUM_BITS  = 48;
	localparam int OUT_SUM_W = 48;
	localparam int RTT_W     = 32;
	localparam int CNT_W     = 32;
	localparam int SEC_W     = 32;
	localparam int USEC_W    = 20;
	localparam int ID_W      = 16;
	localparam int LEN_W     = 16;
	localparam int HW_W      = 4;
	localparam int BYTE_W    = 8;
	localparam int CFG_DATA_W = 16;

	localparam int USEC_PER_SEC  = 1000000;
	localparam int MIN_ICMP_LEN  = 8;
	localparam int MIN_REPLY_LEN = 16;

	localparam logic [BYTE_W-1:0] PROTO_ICMP        = 8'd1;
	localparam logic [BYTE_W-1:0] TYPE_ECHO_REPLY   = 8'd0;
	localparam logic [BYTE_W-1:0] TYPE_ECHO_REQUEST = 8'd8;

	typedef enum logic [1:0] {
		VERDICT_IGNORED = 2'd0,
		VERDICT_REPLY   = 2'd1,
		VERDICT_ERROR   = 2'd2
	} verdict_t;

	typedef enum logic [0:0] {
		REG_OWN_ID       = 1'b0,
		REG_VERBOSE_MODE = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [SEC_W-1:0]  send_sec;
		logic [USEC_W-1:0] send_usec;
		logic [SEC_W-1:0]  recv_sec;
		logic [USEC_W-1:0] recv_usec;
	} ts_t;

	typedef struct packed {
		logic                start;
		logic [SUM_BITS-1:0] dividend;
		logic [CNT_W-1:0]    divisor;
	} div_req_t;

	function automatic logic [SUM_BITS-1:0] sat_add(
		input logic [SUM_BITS-1:0] a,
		input logic [SUM_BITS-1:0] b
	);
		logic [SUM_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
	endfunction

endpackage

>>> sv/irrs_if.sv
// Valid/ready channel interfaces for packet beats in and statistics beats out.
// Depends on irrs_pkg.
interface irrs_in_if;
	logic                          valid;
	logic                          ready;
	logic [irrs_pkg::HW_W-1:0]     header_words;
	logic [irrs_pkg::BYTE_W-1:0]   protocol;
	logic [irrs_pkg::LEN_W-1:0]    packet_len;
	logic [irrs_pkg::BYTE_W-1:0]   msg_type;
	logic [irrs_pkg::ID_W-1:0]     icmp_ident;
	logic [irrs_pkg::ID_W-1:0]     inner_echo_id;
	logic [irrs_pkg::SEC_W-1:0]    send_sec;
	logic [irrs_pkg::USEC_W-1:0]   send_usec;
	logic [irrs_pkg::SEC_W-1:0]    recv_sec;
	logic [irrs_pkg::USEC_W-1:0]   recv_usec;

	modport source (output valid, header_words, protocol, packet_len, msg_type, icmp_ident,
		inner_echo_id, send_sec, send_usec, recv_sec, recv_usec, input ready);
	modport sink (input valid, header_words, protocol, packet_len, msg_type, icmp_ident,
		inner_echo_id, send_sec, send_usec, recv_sec, recv_usec, output ready);
endinterface

interface irrs_out_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        verdict;
	logic [irrs_pkg::RTT_W-1:0]        rtt_us;
	logic [irrs_pkg::CNT_W-1:0]        received_total;
	logic [irrs_pkg::CNT_W-1:0]        error_total;
	logic [irrs_pkg::RTT_W-1:0]        rtt_minimum;
	logic [irrs_pkg::RTT_W-1:0]        rtt_maximum;
	logic [irrs_pkg::OUT_SUM_W-1:0]    rtt_total;
	logic [irrs_pkg::OUT_SUM_W-1:0]    deviation_total;

	modport source (output valid, verdict, rtt_us, received_total, error_total, rtt_minimum,
		rtt_maximum, rtt_total, deviation_total, input ready);
	modport sink (input valid, verdict, rtt_us, received_total, error_total, rtt_minimum,
		rtt_maximum, rtt_total, deviation_total, output ready);
endinterface

>>> sv/irrs_rtt.sv
// Three-stage round-trip time unit: timestamp differences, scale seconds, add and clamp.
// Depends on irrs_pkg.
module irrs_rtt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  irrs_pkg::ts_t              ts,
	output logic                       done,
	output logic [irrs_pkg::RTT_W-1:0] rtt
);
	import irrs_pkg::*;

	localparam int DS_W   = SEC_W + 1;
	localparam int DU_W   = USEC_W + 1;
	localparam int PROD_W = DS_W + DU_W;
	localparam logic signed [DU_W-1:0] USEC_S = DU_W'(USEC_PER_SEC);

	logic                     v_s1, v_s2, v_s3;
	logic signed [DS_W-1:0]   ds_s1;
	logic signed [DU_W-1:0]   du_s1, du_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic [RTT_W-1:0]         rtt_s3;
	logic signed [PROD_W:0]   t;

	always_comb begin
		t = {prod_s2[PROD_W-1], prod_s2} + {{(PROD_W+1-DU_W){du_s2[DU_W-1]}}, du_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ds_s1   <= {1'b0, ts.recv_sec} - {1'b0, ts.send_sec};
		du_s1   <= {1'b0, ts.recv_usec} - {1'b0, ts.send_usec};
		prod_s2 <= ds_s1 * USEC_S;
		du_s2   <= du_s1;
		// clamp negative to zero, saturate above 32 bits
		if (t[PROD_W])
			rtt_s3 <= '0;
		else if (|t[PROD_W-1:RTT_W])
			rtt_s3 <= {RTT_W{1'b1}};
		else
			rtt_s3 <= t[RTT_W-1:0];
	end

	assign done = v_s3;
	assign rtt  = rtt_s3;

endmodule

>>> sv/irrs_div.sv
// Serial restoring divider, one quotient bit per cycle, for the running mean.
// Depends on irrs_pkg.
module irrs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  irrs_pkg::div_req_t            req,
	output logic                          done,
	output logic [irrs_pkg::SUM_BITS-1:0] quotient
);
	import irrs_pkg::*;

	localparam int STEP_W = $clog2(SUM_BITS);

	logic [SUM_BITS-1:0] quo_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    dvs_q;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q;
	logic                done_q;
	logic [CNT_W:0]      trial;
	logic [CNT_W:0]      diff;
	logic                fits;

	always_comb begin
		trial = {rem_q, quo_q[SUM_BITS-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_BITS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> sv/icmp_reply_rtt_stats.sv
// Ping round-trip statistics over received IPv4/ICMP header beats. One packet beat is
// taken at a time; ignored packets and counted error messages go straight to the output
// state, a counted echo reply first through the RTT unit, the update, the serial divider
// that forms the running mean and the deviation sum. The next packet beat is taken once
// the current one has been handed to the output register.
module icmp_reply_rtt_stats (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  irrs_pkg::cfg_idx_t              cfg_index,
	input  logic [irrs_pkg::CFG_DATA_W-1:0] cfg_data,
	irrs_in_if.sink                         pkt,
	irrs_out_if.source                      res
);
	import irrs_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RTT   = 7'b0000010,
		S_UPD   = 7'b0000100,
		S_DIVGO = 7'b0001000,
		S_DIV   = 7'b0010000,
		S_DEV   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [ID_W-1:0]     own_id_q;
	logic                verbose_q;
	logic [CNT_W-1:0]    rcv_q, err_q;
	logic [RTT_W-1:0]    min_q, max_q, rtt_q;
	logic [SUM_BITS-1:0] sum_q, dev_sum_q, mean_q;
	verdict_t            verdict_q;
	logic                out_valid_q;
	logic [1:0]          o_verdict_q;
	logic [RTT_W-1:0]    o_rtt_q, o_min_q, o_max_q;
	logic [CNT_W-1:0]    o_rcv_q, o_err_q;
	logic [OUT_SUM_W-1:0] o_sum_q, o_dev_q;

	logic [LEN_W:0]      plen, lim_icmp, lim_reply;
	logic                icmp_ok, reply_ok, err_ok, out_free;
	ts_t                 ts;
	logic                rtt_done;
	logic [RTT_W-1:0]    rtt_val;
	div_req_t            div_req;
	logic                div_done;
	logic [SUM_BITS-1:0] div_quo;
	logic [SUM_BITS-1:0] rtt_ext, dev;

	always_comb begin
		plen      = {1'b0, pkt.packet_len};
		lim_icmp  = (LEN_W+1)'({pkt.header_words, 2'b00}) + (LEN_W+1)'(MIN_ICMP_LEN);
		lim_reply = (LEN_W+1)'({pkt.header_words, 2'b00}) + (LEN_W+1)'(MIN_REPLY_LEN);
		icmp_ok   = (pkt.protocol == PROTO_ICMP) && (plen >= lim_icmp)
			&& (pkt.msg_type != TYPE_ECHO_REQUEST);
		reply_ok  = icmp_ok && (pkt.msg_type == TYPE_ECHO_REPLY)
			&& (pkt.icmp_ident == own_id_q) && (plen >= lim_reply);
		err_ok    = icmp_ok && (pkt.msg_type != TYPE_ECHO_REPLY) && verbose_q
			&& (pkt.inner_echo_id == own_id_q);
		ts.send_sec  = pkt.send_sec;
		ts.send_usec = pkt.send_usec;
		ts.recv_sec  = pkt.recv_sec;
		ts.recv_usec = pkt.recv_usec;
		div_req.start    = (state_q == S_DIVGO);
		div_req.dividend = sum_q;
		div_req.divisor  = rcv_q;
		rtt_ext  = SUM_BITS'(rtt_q);
		dev      = (mean_q >= rtt_ext) ? (mean_q - rtt_ext) : (rtt_ext - mean_q);
		out_free = !out_valid_q || res.ready;
	end

	assign pkt.ready = (state_q == S_IDLE);

	irrs_rtt u_rtt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pkt.valid && pkt.ready && reply_ok),
		.ts     (ts),
		.done   (rtt_done),
		.rtt    (rtt_val)
	);

	irrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			own_id_q    <= '0;
			verbose_q   <= 1'b0;
			rcv_q       <= '0;
			err_q       <= '0;
			min_q       <= '0;
			max_q       <= '0;
			sum_q       <= '0;
			dev_sum_q   <= '0;
			mean_q      <= '0;
			rtt_q       <= '0;
			verdict_q   <= VERDICT_IGNORED;
			out_valid_q <= 1'b0;
			o_verdict_q <= '0;
			o_rtt_q     <= '0;
			o_rcv_q     <= '0;
			o_err_q     <= '0;
			o_min_q     <= '0;
			o_max_q     <= '0;
			o_sum_q     <= '0;
			o_dev_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OWN_ID:       own_id_q  <= cfg_data[ID_W-1:0];
					REG_VERBOSE_MODE: verbose_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (res.valid && res.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pkt.valid) begin
						rtt_q <= '0;
						if (reply_ok) begin
							verdict_q <= VERDICT_REPLY;
							state_q   <= S_RTT;
						end else if (err_ok) begin
							verdict_q <= VERDICT_ERROR;
							rcv_q     <= (rcv_q == '1) ? rcv_q : rcv_q + 1'b1;
							err_q     <= (err_q == '1) ? err_q : err_q + 1'b1;
							state_q   <= S_OUT;
						end else begin
							verdict_q <= VERDICT_IGNORED;
							state_q   <= S_OUT;
						end
					end
				end
				S_RTT: begin
					if (rtt_done) begin
						rtt_q   <= rtt_val;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					rcv_q <= (rcv_q == '1) ? rcv_q : rcv_q + 1'b1;
					if (rtt_q < min_q || min_q == '0)
						min_q <= rtt_q;
					if (rtt_q > max_q)
						max_q <= rtt_q;
					sum_q   <= sat_add(sum_q, rtt_ext);
					state_q <= S_DIVGO;
				end
				S_DIVGO: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						mean_q  <= div_quo;
						state_q <= S_DEV;
					end
				end
				S_DEV: begin
					dev_sum_q <= sat_add(dev_sum_q, dev);
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						o_verdict_q <= verdict_q;
						o_rtt_q     <= rtt_q;
						o_rcv_q     <= rcv_q;
						o_err_q     <= err_q;
						o_min_q     <= min_q;
						o_max_q     <= max_q;
						o_sum_q     <= OUT_SUM_W'(sum_q);
						o_dev_q     <= OUT_SUM_W'(dev_sum_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid           = out_valid_q;
	assign res.verdict         = o_verdict_q;
	assign res.rtt_us          = o_rtt_q;
	assign res.received_total  = o_rcv_q;
	assign res.error_total     = o_err_q;
	assign res.rtt_minimum     = o_min_q;
	assign res.rtt_maximum     = o_max_q;
	assign res.rtt_total       = o_sum_q;
	assign res.deviation_total = o_dev_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		pkt.valid && pkt.ready |=> !pkt.ready)
		else $error("packet beat taken while busy");
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside division");
	a_rtt_done_in_rtt: assert property (@(posedge clk) disable iff (!arst_n)
		rtt_done |-> state_q == S_RTT)
		else $error("rtt unit finished outside rtt state");
	a_err_le_rcv: assert property (@(posedge clk) disable iff (!arst_n)
		err_q <= rcv_q)
		else $error("error count exceeds receive count");
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		min_q != '0 |-> min_q <= max_q)
		else $error("minimum rtt above maximum rtt");

endmodule
